### rtl/base64_stream_encoder_macros.svh
// Assertion macros shared by the checker of the Base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Checks a property on the rising edge of clk, ignored while arst_n is low.
`define B64_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a signal holds in the cycle after a condition.
`define B64_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

### rtl/b64_pkg.sv
// Types, constants and the alphabet lookup of the Base64 stream encoder.
package b64_pkg;

	localparam logic [6:0] PAD_CHAR = 7'd61;

	localparam logic [1:0] POS_EMPTY = 2'd0;
	localparam logic [1:0] POS_ONE   = 2'd1;
	localparam logic [1:0] POS_TWO   = 2'd2;

	localparam logic [1:0] LAST_SLOT = 2'd3;

	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  pads;
		logic        last;
	} grp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		case (v) inside
			[6'd0:6'd25]:  c = 7'd65 + {1'b0, v};
			[6'd26:6'd51]: c = 7'd71 + {1'b0, v};
			[6'd52:6'd61]: c = {1'b0, v} - 7'd4;
			6'd62:         c = 7'd43;
			default:       c = 7'd47;
		endcase
		return c;
	endfunction

endpackage

### rtl/b64_byte_if.sv
// Input channel carrying one raw byte word and its end-of-message flag.
interface b64_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/b64_char_if.sv
// Output channel carrying one encoded character word and its end flag.
interface b64_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

### rtl/b64_fifo.sv
// Short queue of byte groups awaiting encoding between the byte front end and the character back end.
module b64_fifo
	import b64_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  grp_entry_t wr_entry,
	input  logic       pop,
	output grp_entry_t rd_entry,
	output q_flags_t   flags
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	grp_entry_t        mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign flags.full  = (count_q == CW'(DEPTH));
	assign flags.empty = (count_q == '0);
	assign do_push     = push && !flags.full;
	assign do_pop      = pop && !flags.empty;
	assign rd_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/b64_front.sv
// Front end: collects bytes into three-byte groups and queues each finished or message-ending group.
module b64_front
	import b64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	b64_byte_if.sink   in,
	input  q_flags_t   flags,
	output logic       push,
	output grp_entry_t entry
);

	logic [15:0] pend_q;
	logic [1:0]  pos_q;
	logic        accept;

	assign in.ready = !flags.full;
	assign accept   = in.valid && in.ready;

	always_comb begin
		push        = 1'b0;
		entry.bits  = {pend_q, in.data_byte};
		entry.pads  = 2'd0;
		entry.last  = in.last_byte;
		case (pos_q)
			POS_TWO: begin
				push = accept;
			end
			POS_ONE: begin
				push       = accept && in.last_byte;
				entry.bits = {pend_q[7:0], in.data_byte, 8'd0};
				entry.pads = 2'd1;
			end
			default: begin
				push       = accept && in.last_byte;
				entry.bits = {in.data_byte, 16'd0};
				entry.pads = 2'd2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pos_q  <= POS_EMPTY;
		end else if (accept) begin
			if (push) begin
				pend_q <= '0;
				pos_q  <= POS_EMPTY;
			end else if (pos_q == POS_ONE) begin
				pend_q <= {pend_q[7:0], in.data_byte};
				pos_q  <= POS_TWO;
			end else begin
				pend_q <= {8'd0, in.data_byte};
				pos_q  <= POS_ONE;
			end
		end
	end

endmodule

### rtl/b64_back.sv
// Back end: each queued group gives four chars, one per unstalled cycle, via an output register.
module b64_back
	import b64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  grp_entry_t rd_entry,
	input  q_flags_t   flags,
	output logic       pop,
	b64_char_if.source out
);

	grp_entry_t  grp_q;
	logic [1:0]  idx_q;
	logic        busy_q;
	logic        ovalid_q;
	logic [6:0]  ochar_q;
	logic        olast_q;
	logic        load;
	logic        done;
	logic [5:0]  sextet;
	logic        is_pad;
	logic [6:0]  next_char;

	assign out.valid     = ovalid_q;
	assign out.out_char  = ochar_q;
	assign out.last_char = olast_q;

	assign load = busy_q && (!ovalid_q || out.ready);
	assign done = load && (idx_q == LAST_SLOT);
	assign pop  = (!busy_q || done) && !flags.empty;

	always_comb begin
		case (idx_q)
			2'd0:    sextet = grp_q.bits[23:18];
			2'd1:    sextet = grp_q.bits[17:12];
			2'd2:    sextet = grp_q.bits[11:6];
			default: sextet = grp_q.bits[5:0];
		endcase
		case (grp_q.pads)
			2'd1:    is_pad = (idx_q == 2'd3);
			2'd2:    is_pad = idx_q[1];
			default: is_pad = 1'b0;
		endcase
		next_char = is_pad ? PAD_CHAR : b64_char(sextet);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= rd_entry;
		end
		if (load) begin
			ochar_q <= next_char;
			olast_q <= grp_q.last && (idx_q == LAST_SLOT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/base64_stream_encoder.sv
// Streaming Base64 encoder: one byte word in, four character words out per three-byte group.
// A group passes the queue, the group register and the output register before its first character is valid.
// The back end gives one character per cycle while the output is not stalled.
// A byte is taken every cycle while the group queue has room.
// Reset (arst_n low) empties the queue, clears the pending bytes and drops the output valid.
module base64_stream_encoder
	import b64_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	b64_byte_if.sink   in,
	b64_char_if.source out
);

	grp_entry_t wr_entry;
	grp_entry_t rd_entry;
	q_flags_t   flags;
	logic       push;
	logic       pop;

	b64_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.flags  (flags),
		.push   (push),
		.entry  (wr_entry)
	);

	b64_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.flags    (flags)
	);

	b64_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_entry (rd_entry),
		.flags    (flags),
		.pop      (pop),
		.out      (out)
	);

endmodule

### rtl/b64_checker.sv
// Port checker of the Base64 stream encoder and its bind to the top level.
`include "base64_stream_encoder_macros.svh"

module b64_checker
	import b64_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       last_char
);

	logic [1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (out_valid && out_ready) begin
			slot_q <= slot_q + 1'b1;
		end
	end

	`B64_ASSERT(a_last_on_fourth, (out_valid && last_char) |-> (slot_q == LAST_SLOT), "last_char off the fourth slot")
	`B64_ASSERT(a_pad_in_tail, (out_valid && out_char == PAD_CHAR) |-> slot_q[1], "pad in the first half of a group")
	`B64_ASSERT(a_valid_holds, (out_valid && !out_ready) |=> out_valid, "output valid dropped while stalled")
	`B64_ASSERT_HOLD(a_word_holds, out_valid && !out_ready, {out_char, last_char}, "output word changed while stalled")

endmodule

bind base64_stream_encoder b64_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_char  (out.out_char),
	.last_char (out.last_char)
);

### tb/tb_base64_stream_encoder.sv
// Testbench for the streaming Base64 encoder: random and directed messages checked against a predictor.
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
	import b64_pkg::*;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} char_word_t;

	logic clk = 1'b0;
	logic arst_n;

	b64_byte_if byte_bus ();
	b64_char_if char_bus ();

	base64_stream_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(byte_bus),
		.out(char_bus)
	);

	char_word_t expected_chars[$];
	logic [15:0] enc_pending = '0;
	logic [1:0]  enc_pos = POS_EMPTY;

	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_byte(input logic [7:0] b, input logic l);
		logic [23:0] grp;
		int pads;
		int idx;
		char_word_t w;
		grp = '0;
		pads = 0;
		if (enc_pos == POS_TWO) begin
			grp = {enc_pending, b};
		end else if (!l) begin
			enc_pending = (enc_pos == POS_ONE) ? {enc_pending[7:0], b} : {8'h00, b};
			enc_pos = (enc_pos == POS_ONE) ? POS_TWO : POS_ONE;
			return;
		end else if (enc_pos == POS_ONE) begin
			grp = {enc_pending[7:0], b, 8'h00};
			pads = 1;
		end else begin
			grp = {b, 16'h0000};
			pads = 2;
		end
		for (int k = 0; k < 4; k++) begin
			idx = grp[23 - 6 * k -: 6];
			w.ch = (k >= 4 - pads) ? PAD_CHAR : ALPHABET[8 * (63 - idx) +: 7];
			w.last = l && (k == 3);
			expected_chars.push_back(w);
		end
		enc_pending = '0;
		enc_pos = POS_EMPTY;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(posedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.data_byte <= b;
		byte_bus.last_byte <= l;
		@(posedge clk);
		while (!byte_bus.ready)
			@(posedge clk);
		predict_byte(b, l);
	endtask

	task automatic drain_encoder();
		byte_bus.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_message(input logic [7:0] msg[$]);
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	task automatic test_directed_messages();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_message('{8'h00});
		send_message('{8'hFF});
		send_message('{8'h00, 8'h00});
		send_message('{8'hFF, 8'hFF});
		send_message('{8'h4D, 8'h61});
		send_message('{8'hFF, 8'hFF, 8'hFF});
		send_message('{8'h00, 8'h00, 8'h00});
		send_message('{8'hFB, 8'hEF, 8'hBE});
		send_message('{8'h00, 8'h10, 8'h83, 8'h10, 8'h51, 8'h87, 8'h20});
		drain_encoder();
	endtask

	task automatic test_random_messages(input int idle_pct, input int stall_pct,
			input int n_bytes);
		int sent;
		int len;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_bytes) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(255)), i == len - 1);
			sent += len;
		end
		drain_encoder();
	endtask

	// The output side holds off long enough for the group queue to fill and stall the input.
	task automatic test_output_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 200;
		for (int i = 0; i < 30; i++)
			send_byte(8'($urandom_range(255)), i == 13 || i == 29);
		drain_encoder();
	endtask

	task automatic test_sender_pause();
		int len;
		send_idle_pct = 23;
		recv_stall_pct = 23;
		for (int m = 0; m < 4; m++) begin
			len = $urandom_range(7, 1);
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(255)), i == len - 1);
			drain_encoder();
		end
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		char_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && hold_off_cycles != 0) begin
				stall_left = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				char_bus.ready <= 1'b0;
			end else begin
				char_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : char_check
		char_word_t got;
		char_word_t want;
		if (arst_n && char_bus.valid && char_bus.ready) begin
			got.ch = char_bus.out_char;
			got.last = char_bus.last_char;
			if (expected_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected char word %0d last %0b", $realtime, got.ch, got.last);
			end else begin
				want = expected_chars.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: char expected %0d last %0b, got %0d last %0b",
							$realtime, want.ch, want.last, got.ch, got.last);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = 8'h00;
		byte_bus.last_byte = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_messages();
		test_output_hold_off();
		test_sender_pause();
		test_random_messages(0, 0, 75);
		test_random_messages(61, 0, 75);
		test_random_messages(0, 61, 75);
		test_random_messages(23, 23, 75);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_chars.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
